// ----- hw/rtl/sgi_pkg.sv -----
// Shared widths and types for the segment intersection unit.
package sgi_pkg;

   localparam int CW      = 16;
   localparam int DW      = CW + 1;
   localparam int PW      = 2 * DW;
   localparam int XW      = PW + 1;
   localparam int MW      = XW + DW;
   localparam int NW      = MW + 2;
   localparam int D2W     = XW + 1;
   localparam int QW      = DW;
   localparam int NPTS    = 4;
   localparam int NTST    = 2 * NPTS;
   localparam int IN_W    = 2 * NPTS * CW;
   localparam int OUT_W   = ((1 + 2 * CW + 7) / 8) * 8;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [DW-1:0] diff_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [XW-1:0] cross_type;
   typedef logic [NW-1:0]        num_type;
   typedef logic [D2W-1:0]       den2_type;
   typedef logic [QW-1:0]        quo_type;

   typedef struct packed {
      logic      hit;
      logic      par;
      logic      neg_x;
      logic      neg_y;
      coord_type base_x;
      coord_type base_y;
   } side_type;

endpackage

// ----- hw/rtl/segment_intersection_unit.sv -----
// Top level of the segment intersection unit.
// Takes one segment pair per cycle while the result side does not stall. 5 front stages, the
// 17-stage divider and the output register make 23 register stages, the first of them loaded
// at the edge that accepts the request beat. The result says whether the segments meet and
// gives the meeting point in Q8.8, rounded to nearest with ties away from zero; a miss returns
// all zero. The latency is set by the cross products, the sign tests and the divider that forms
// the rounded point. A stall on the result side holds the whole pipeline; no beat is dropped.
module segment_intersection_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [sgi_pkg::IN_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // hit, meet_x, meet_y, zero pad
   output logic [sgi_pkg::OUT_W-1:0] rsp_tdata
);

   localparam int QW = sgi_pkg::QW;
   localparam int CW = sgi_pkg::CW;
   localparam int DW = sgi_pkg::DW;
   localparam int XW = sgi_pkg::XW;

   logic en;

   // stage 1
   logic               v1_ff;
   sgi_pkg::diff_type  x1_ff [sgi_pkg::NPTS];
   sgi_pkg::diff_type  y1_ff [sgi_pkg::NPTS];

   // stage 2
   logic               v2_ff;
   sgi_pkg::prod_type  den_a_ff, den_b_ff, n1_a_ff, n1_b_ff, n2_a_ff, n2_b_ff;
   sgi_pkg::prod_type  den_a_in, den_b_in, n1_a_in, n1_b_in, n2_a_in, n2_b_in;
   sgi_pkg::prod_type  cr_a_ff [sgi_pkg::NTST];
   sgi_pkg::prod_type  cr_b_ff [sgi_pkg::NTST];
   sgi_pkg::prod_type  dt_a_ff [sgi_pkg::NTST];
   sgi_pkg::prod_type  dt_b_ff [sgi_pkg::NTST];
   sgi_pkg::prod_type  cr_a_in [sgi_pkg::NTST];
   sgi_pkg::prod_type  cr_b_in [sgi_pkg::NTST];
   sgi_pkg::prod_type  dt_a_in [sgi_pkg::NTST];
   sgi_pkg::prod_type  dt_b_in [sgi_pkg::NTST];
   sgi_pkg::diff_type  rx2_ff, ry2_ff;
   sgi_pkg::diff_type  x2_ff [sgi_pkg::NPTS];
   sgi_pkg::diff_type  y2_ff [sgi_pkg::NPTS];
   sgi_pkg::diff_type  rx, ry, sx, sy, wx, wy;

   // stage 3
   logic               v3_ff;
   sgi_pkg::cross_type den3_ff, n1_3_ff, n2_3_ff;
   sgi_pkg::cross_type den3_in, n1_3_in, n2_3_in;
   sgi_pkg::diff_type  rx3_ff, ry3_ff;
   sgi_pkg::coord_type x0_3_ff, y0_3_ff, px3_ff, py3_ff;
   sgi_pkg::coord_type px3_in, py3_in;
   logic               ph3_ff, ph3_in;
   logic [sgi_pkg::NTST-1:0] on_seg;

   // stage 4
   logic               v4_ff;
   sgi_pkg::side_type  side4_ff, side4_in;
   logic [XW-1:0]      an4_ff, ad4_ff, an4_in, ad4_in;
   logic [DW-1:0]      arx4_ff, ary4_ff, arx4_in, ary4_in;

   // stage 5
   logic               v5_ff;
   sgi_pkg::side_type  side5_ff;
   logic [sgi_pkg::MW-1:0] mx5_ff, my5_ff;
   logic [XW-1:0]      ad5_ff;

   // divider stages
   logic               vd_ff [QW];
   sgi_pkg::side_type  sd_ff [QW];
   sgi_pkg::num_type   num_x, num_y;
   sgi_pkg::den2_type  den2;
   sgi_pkg::quo_type   qx, qy;

   // output
   logic               vo_ff;
   logic               hit_ff, hit_in;
   sgi_pkg::coord_type ox_ff, oy_ff, ox_in, oy_in;

   assign en         = !vo_ff || rsp_tready;
   assign req_tready = en;

   // stage 1: capture and sign-extend
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         for (int i = 0; i < sgi_pkg::NPTS; i++) begin
            x1_ff[i] <= DW'(signed'(req_tdata[2*i*CW +: CW]));
            y1_ff[i] <= DW'(signed'(req_tdata[(2*i+1)*CW +: CW]));
         end
      end
   end

   // stage 2: products
   always_comb begin
      rx = x1_ff[1] - x1_ff[0];
      ry = y1_ff[1] - y1_ff[0];
      sx = x1_ff[3] - x1_ff[2];
      sy = y1_ff[3] - y1_ff[2];
      wx = x1_ff[2] - x1_ff[0];
      wy = y1_ff[2] - y1_ff[0];
      den_a_in = rx * sy;
      den_b_in = ry * sx;
      n1_a_in  = wx * sy;
      n1_b_in  = wy * sx;
      n2_a_in  = wx * ry;
      n2_b_in  = wy * rx;
   end

   for (genvar g = 0; g < 2; g++) begin : g_seg
      for (genvar c = 0; c < sgi_pkg::NPTS; c++) begin : g_cand
         sgi_pkg::diff_type bax, bay, cax, cay, cbx, cby;
         always_comb begin
            bax = x1_ff[2*g+1] - x1_ff[2*g];
            bay = y1_ff[2*g+1] - y1_ff[2*g];
            cax = x1_ff[c] - x1_ff[2*g];
            cay = y1_ff[c] - y1_ff[2*g];
            cbx = x1_ff[c] - x1_ff[2*g+1];
            cby = y1_ff[c] - y1_ff[2*g+1];
            cr_a_in[g*sgi_pkg::NPTS+c] = bax * cay;
            cr_b_in[g*sgi_pkg::NPTS+c] = bay * cax;
            dt_a_in[g*sgi_pkg::NPTS+c] = cax * cbx;
            dt_b_in[g*sgi_pkg::NPTS+c] = cay * cby;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         den_a_ff <= den_a_in;
         den_b_ff <= den_b_in;
         n1_a_ff  <= n1_a_in;
         n1_b_ff  <= n1_b_in;
         n2_a_ff  <= n2_a_in;
         n2_b_ff  <= n2_b_in;
         cr_a_ff  <= cr_a_in;
         cr_b_ff  <= cr_b_in;
         dt_a_ff  <= dt_a_in;
         dt_b_ff  <= dt_b_in;
         rx2_ff   <= rx;
         ry2_ff   <= ry;
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
      end
   end

   // stage 3: cross products, collinear endpoint search
   always_comb begin
      den3_in = XW'(den_a_ff) - XW'(den_b_ff);
      n1_3_in = XW'(n1_a_ff) - XW'(n1_b_ff);
      n2_3_in = XW'(n2_a_ff) - XW'(n2_b_ff);
      for (int k = 0; k < sgi_pkg::NTST; k++) begin
         on_seg[k] = ((XW'(cr_a_ff[k]) - XW'(cr_b_ff[k])) == '0) &&
                     ((XW'(dt_a_ff[k]) + XW'(dt_b_ff[k])) <= sgi_pkg::cross_type'(0));
      end
      ph3_in = 1'b0;
      px3_in = '0;
      py3_in = '0;
      for (int c = sgi_pkg::NPTS - 1; c >= 0; c--) begin
         if (on_seg[c] && on_seg[sgi_pkg::NPTS+c]) begin
            ph3_in = 1'b1;
            px3_in = CW'(x2_ff[c]);
            py3_in = CW'(y2_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         den3_ff <= den3_in;
         n1_3_ff <= n1_3_in;
         n2_3_ff <= n2_3_in;
         rx3_ff  <= rx2_ff;
         ry3_ff  <= ry2_ff;
         x0_3_ff <= CW'(x2_ff[0]);
         y0_3_ff <= CW'(y2_ff[0]);
         px3_ff  <= px3_in;
         py3_ff  <= py3_in;
         ph3_ff  <= ph3_in;
      end
   end

   // stage 4: parameter range tests, magnitudes
   sgi_pkg::cross_type na, nb, dd;
   logic               dneg;
   always_comb begin
      dneg = den3_ff[XW-1];
      dd   = dneg ? -den3_ff : den3_ff;
      na   = dneg ? -n1_3_ff : n1_3_ff;
      nb   = dneg ? -n2_3_ff : n2_3_ff;
      side4_in = '0;
      if (den3_ff == '0) begin
         side4_in.par    = 1'b1;
         side4_in.hit    = (n2_3_ff == '0) && ph3_ff;
         side4_in.base_x = px3_ff;
         side4_in.base_y = py3_ff;
      end else begin
         side4_in.par    = 1'b0;
         side4_in.hit    = !na[XW-1] && (na <= dd) && !nb[XW-1] && (nb <= dd);
         side4_in.base_x = x0_3_ff;
         side4_in.base_y = y0_3_ff;
      end
      side4_in.neg_x = (n1_3_ff[XW-1] != dneg) != rx3_ff[DW-1];
      side4_in.neg_y = (n1_3_ff[XW-1] != dneg) != ry3_ff[DW-1];
      an4_in  = n1_3_ff[XW-1] ? XW'(-n1_3_ff) : XW'(n1_3_ff);
      ad4_in  = XW'(dd);
      arx4_in = rx3_ff[DW-1] ? DW'(-rx3_ff) : DW'(rx3_ff);
      ary4_in = ry3_ff[DW-1] ? DW'(-ry3_ff) : DW'(ry3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         side4_ff <= side4_in;
         an4_ff   <= an4_in;
         ad4_ff   <= ad4_in;
         arx4_ff  <= arx4_in;
         ary4_ff  <= ary4_in;
      end
   end

   // stage 5: scale the numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         side5_ff <= side4_ff;
         mx5_ff   <= sgi_pkg::MW'(an4_ff) * sgi_pkg::MW'(arx4_ff);
         my5_ff   <= sgi_pkg::MW'(an4_ff) * sgi_pkg::MW'(ary4_ff);
         ad5_ff   <= ad4_ff;
      end
   end

   // rounded quotient: (2*n*k + d) / (2*d)
   assign num_x = {mx5_ff, 1'b0} + sgi_pkg::NW'(ad5_ff);
   assign num_y = {my5_ff, 1'b0} + sgi_pkg::NW'(ad5_ff);
   assign den2  = {ad5_ff, 1'b0};

   sgi_div u_div_x (
      .clock  (clock),
      .en     (en),
      .num_in (num_x),
      .den_in (den2),
      .quo    (qx)
   );

   sgi_div u_div_y (
      .clock  (clock),
      .en     (en),
      .num_in (num_y),
      .den_in (den2),
      .quo    (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QW; j++) begin
            vd_ff[j] <= 1'b0;
         end
      end else if (en) begin
         vd_ff[0] <= v5_ff;
         for (int j = 1; j < QW; j++) begin
            vd_ff[j] <= vd_ff[j-1];
         end
      end
      if (en) begin
         sd_ff[0] <= side5_ff;
         for (int j = 1; j < QW; j++) begin
            sd_ff[j] <= sd_ff[j-1];
         end
      end
   end

   // output stage
   sgi_pkg::side_type sl;
   logic signed [DW:0] ofs_x, ofs_y, sum_x, sum_y;
   always_comb begin
      sl    = sd_ff[QW-1];
      ofs_x = '0;
      ofs_y = '0;
      if (!sl.par) begin
         ofs_x = sl.neg_x ? -(DW+1)'(qx) : (DW+1)'(qx);
         ofs_y = sl.neg_y ? -(DW+1)'(qy) : (DW+1)'(qy);
      end
      sum_x  = (DW+1)'(sl.base_x) + ofs_x;
      sum_y  = (DW+1)'(sl.base_y) + ofs_y;
      hit_in = sl.hit;
      ox_in  = sl.hit ? CW'(sum_x) : '0;
      oy_in  = sl.hit ? CW'(sum_y) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= vd_ff[QW-1];
      end
      if (en) begin
         hit_ff <= hit_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = sgi_pkg::OUT_W'({oy_ff, ox_ff, hit_ff});

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[2*CW:1] == '0)
      else $error("miss with nonzero point");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   a_par_quiet: assert property (@(posedge clock) disable iff (reset)
      en && v3_ff && den3_ff == '0 && n2_3_ff != '0 |=> !side4_ff.hit)
      else $error("parallel non-collinear pair flagged as hit");

endmodule

// ----- hw/rtl/sgi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module sgi_div (
   input  logic              clock,
   input  logic              en,
   input  sgi_pkg::num_type  num_in,
   input  sgi_pkg::den2_type den_in,
   output sgi_pkg::quo_type  quo
);

   sgi_pkg::num_type  rem_ff [sgi_pkg::QW];
   sgi_pkg::den2_type den_ff [sgi_pkg::QW];
   sgi_pkg::quo_type  quo_ff [sgi_pkg::QW];

   for (genvar j = 0; j < sgi_pkg::QW; j++) begin : g_stage
      sgi_pkg::num_type  rem_prev;
      sgi_pkg::den2_type den_prev;
      sgi_pkg::quo_type  quo_prev;
      sgi_pkg::num_type  trial;
      sgi_pkg::num_type  rem_in;
      sgi_pkg::quo_type  quo_in;

      if (j == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign quo_prev = quo_ff[j-1];
      end

      always_comb begin
         trial  = sgi_pkg::num_type'(den_prev) << (sgi_pkg::QW - 1 - j);
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            quo_in[sgi_pkg::QW-1-j] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_prev;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[sgi_pkg::QW-1];

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking stream testbench for the segment intersection unit.
module tb;

   localparam int CW = sgi_pkg::CW;
   localparam int IN_W = sgi_pkg::IN_W;
   localparam int OUT_W = sgi_pkg::OUT_W;
   localparam int LATENCY = 22;
   localparam int N_RANDOM = 1150;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic               hit;
      sgi_pkg::coord_type meet_x;
      sgi_pkg::coord_type meet_y;
   } meet_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [IN_W-1:0]      req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [OUT_W-1:0]     rsp_tdata;

   logic [IN_W-1:0] pending_pairs[$];
   meet_type        expected_meets[$];
   int              mismatch_count;
   int              orphan_count;
   int              queued_count;
   int              accepted_count;
   bit              stimulus_done;
   bit              hold_sender;
   int              long_stall_cycles;
   int              burst_left;
   int              gap_left;
   int              stall_phase;

   segment_intersection_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [39:0] cross2(logic signed [39:0] ax, logic signed [39:0] ay,
                                                 logic signed [39:0] bx, logic signed [39:0] by);
      return ax * by - ay * bx;
   endfunction

   function automatic bit lies_on(logic signed [39:0] cx, logic signed [39:0] cy,
                                  logic signed [39:0] ax, logic signed [39:0] ay,
                                  logic signed [39:0] bx, logic signed [39:0] by);
      logic signed [39:0] dot;
      if (cross2(bx - ax, by - ay, cx - ax, cy - ay) != 0) return 1'b0;
      dot = (cx - ax) * (cx - bx) + (cy - ay) * (cy - by);
      return dot <= 0;
   endfunction

   // round(n * k / d), ties away from zero
   function automatic logic signed [39:0] round_ratio(logic signed [39:0] n,
                                                      logic signed [39:0] k,
                                                      logic signed [39:0] d);
      logic signed [79:0] num;
      logic signed [79:0] den;
      logic [79:0] an;
      logic [79:0] ad;
      logic [79:0] q;
      num = n;
      den = d;
      num = num * k;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q = (2 * an + ad) / (2 * ad);
      return ((num < 0) != (den < 0)) ? -$signed(q[39:0]) : $signed(q[39:0]);
   endfunction

   function automatic meet_type intersect_segments(logic [IN_W-1:0] pair);
      logic signed [39:0] px[4];
      logic signed [39:0] py[4];
      logic signed [39:0] rx, ry, sx, sy, wx, wy, den, n1, n2;
      meet_type m;
      m = '0;
      for (int i = 0; i < 4; i++) begin
         px[i] = $signed(pair[2*i*CW +: CW]);
         py[i] = $signed(pair[(2*i+1)*CW +: CW]);
      end
      rx = px[1] - px[0]; ry = py[1] - py[0];
      sx = px[3] - px[2]; sy = py[3] - py[2];
      wx = px[2] - px[0]; wy = py[2] - py[0];
      den = cross2(rx, ry, sx, sy);
      n1 = cross2(wx, wy, sx, sy);
      n2 = cross2(wx, wy, rx, ry);
      if (den == 0) begin
         if (n2 == 0) begin
            for (int i = 0; i < 4; i++) begin
               if (!m.hit && lies_on(px[i], py[i], px[0], py[0], px[1], py[1]) &&
                   lies_on(px[i], py[i], px[2], py[2], px[3], py[3])) begin
                  m.hit = 1'b1;
                  m.meet_x = px[i][CW-1:0];
                  m.meet_y = py[i][CW-1:0];
               end
            end
         end
      end else begin
         if (den < 0) begin
            den = -den; n1 = -n1; n2 = -n2;
            if (n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den) begin
               m.hit = 1'b1;
               m.meet_x = CW'(px[0] + round_ratio(-n1, rx, -den));
               m.meet_y = CW'(py[0] + round_ratio(-n1, ry, -den));
            end
         end else if (n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den) begin
            m.hit = 1'b1;
            m.meet_x = CW'(px[0] + round_ratio(n1, rx, den));
            m.meet_y = CW'(py[0] + round_ratio(n1, ry, den));
         end
      end
      return m;
   endfunction

   function automatic logic [IN_W-1:0] pack_pair(int c[8]);
      logic [IN_W-1:0] p;
      for (int i = 0; i < 8; i++) p[i*CW +: CW] = c[i][CW-1:0];
      return p;
   endfunction

   function automatic int small_coord();
      return $signed($urandom_range(0, 2047)) - 1024;
   endfunction

   function automatic logic [IN_W-1:0] random_pair();
      int c[8];
      int mode;
      int k;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) c[i] = (mode < 2) ? $urandom : small_coord();
      if (mode == 5) begin
         // collinear: second segment on the line of the first
         k = $urandom_range(0, 8) - 4;
         c[2] = c[6] - 2 * c[4]; // overwritten below
         c[4] = c[0] + k * 16; c[5] = c[1] + k * 16;
         c[6] = c[0] + (k + $urandom_range(0, 8)) * 16;
         c[7] = c[1] + (c[6] - c[0]);
         c[2] = c[0] + 64; c[3] = c[1] + 64;
      end else if (mode == 6) begin
         // parallel offset
         c[4] = c[0] + 3; c[5] = c[1];
         c[6] = c[2] + 3; c[7] = c[3];
      end else if (mode == 7) begin
         // shared endpoint
         c[4] = c[2]; c[5] = c[3];
      end else if (mode == 8) begin
         // degenerate segment
         c[6] = c[4]; c[7] = c[5];
      end
      return pack_pair(c);
   endfunction

   task automatic queue_pair(logic [IN_W-1:0] p);
      pending_pairs.insert(pending_pairs.size(), p);
      queued_count++;
   endtask

   task automatic add_pair(int a, int b, int c, int d, int e, int f, int g, int h);
      int v[8];
      v = '{a, b, c, d, e, f, g, h};
      queue_pair(pack_pair(v));
   endtask

   initial begin
      hold_sender = 1'b0;
      stimulus_done = 1'b0;
      long_stall_cycles = 0;
      queued_count = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      add_pair(0, 0, 256, 256, 0, 256, 256, 0);
      add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      add_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
      add_pair(0, 0, 256, 0, 256, 0, 512, 100);
      add_pair(0, 0, 256, 0, 0, 10, 256, 10);
      add_pair(0, 0, 512, 0, 256, 0, 768, 0);
      add_pair(256, 0, 768, 0, 0, 0, 512, 0);
      add_pair(0, 0, 256, 0, 512, 0, 768, 0);
      add_pair(5, 5, 5, 5, 5, 5, 5, 5);
      add_pair(5, 5, 5, 5, 0, 0, 10, 10);
      add_pair(5, 5, 5, 5, 6, 6, 6, 6);
      add_pair(0, 0, 3, 1, 0, 1, 3, 0);
      add_pair(0, 0, 1, 1, 0, 1, 1, 0);
      add_pair(0, 0, -1, -3, 0, -1, -3, 0);
      add_pair(0, 0, 100, 0, 50, 1, 50, 200);
      add_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
      add_pair(0, 0, 256, 0, 256, 0, 256, 256);
      add_pair(-1, -1, -1, -1, -1, -1, -1, -1);
      add_pair(-21846, 21845, 21845, -21846, 1, 1, -1, -1);
      wait (accepted_count == queued_count);
      hold_sender = 1'b1;
      wait (expected_meets.size() == 0);
      @(negedge clock);
      hold_sender = 1'b0;
      for (int i = 0; i < 60; i++) queue_pair(random_pair());
      long_stall_cycles = 200;
      for (int i = 0; i < N_RANDOM - 60; i++) queue_pair(random_pair());
      wait (accepted_count == queued_count);
      stimulus_done = 1'b1;
   end

   // sender: bursts and gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) gap_left--;
         if (pending_pairs.size() != 0 && !hold_sender && gap_left == 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs.pop_front();
            if (burst_left == 0) burst_left = $urandom_range(1, 30);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_phase = 0;
      end else if (long_stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         long_stall_cycles--;
      end else begin
         stall_phase = (stall_phase + 1) % 64;
         if (stall_phase < 24) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // predict each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         accepted_count = 0;
      end else if (req_tvalid && req_tready) begin
         expected_meets.insert(expected_meets.size(), intersect_segments(req_tdata));
         accepted_count++;
      end
   end

   always @(posedge clock) begin
      meet_type got;
      meet_type want;
      if (reset) begin
         mismatch_count <= 0;
         orphan_count <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[0 +: 33];
         got.hit = rsp_tdata[0];
         got.meet_x = rsp_tdata[1 +: CW];
         got.meet_y = rsp_tdata[1 + CW +: CW];
         if (expected_meets.size() == 0) begin
            orphan_count <= orphan_count + 1;
            if (mismatch_count + orphan_count < MAX_REPORTS)
               $display("unexpected beat: %h", rsp_tdata);
         end else begin
            want = expected_meets.pop_front();
            if (got !== want) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < MAX_REPORTS)
                  $display("mismatch: expected hit=%0d x=%0d y=%0d, got hit=%0d x=%0d y=%0d",
                           want.hit, want.meet_x, want.meet_y,
                           got.hit, got.meet_x, got.meet_y);
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (expected_meets.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && orphan_count == 0 && expected_meets.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/sgi_pkg.sv
hw/rtl/sgi_div.sv
hw/rtl/segment_intersection_unit.sv
tb/sv/tb.sv
